FILE: rtl/binary_to_decimal_ascii_defines.svh
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii_defines.svh
// Assertion macros shared by the converter RTL.
// ---------------------------------------------------------------------------
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define B2DA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define B2DA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/b2da_pkg.sv
// ---------------------------------------------------------------------------
// b2da_pkg
// Shared constants, types and digit helpers for the decimal converter.
// ---------------------------------------------------------------------------
package b2da_pkg;

  localparam int DIGIT_COUNT = 20;
  localparam int VALUE_BITS  = 64;
  localparam int DIGIT_W     = 4;
  localparam int CHAR_W      = 6;
  localparam int BIT_CNT_W   = $clog2(VALUE_BITS);
  localparam int REM_W       = $clog2(DIGIT_COUNT + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE = DIGIT_W'(5);
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = DIGIT_W'(9);

  typedef logic [DIGIT_W-1:0] digit_t;

  // Queue entry: value plus the front's zero classification.
  typedef struct packed {
    logic                  is_zero;
    logic [VALUE_BITS-1:0] value;
  } qentry_t;

  // One decimal digit times two plus carry-in, modulo ten.
  function automatic digit_t dbl_digit(input digit_t d, input logic cin);
    logic [DIGIT_W:0] twice;
    twice = {d, cin};
    if (d >= DIGIT_FIVE) begin
      dbl_digit = DIGIT_W'(twice - {1'b0, DIGIT_TEN});
    end else begin
      dbl_digit = twice[DIGIT_W-1:0];
    end
  endfunction

  // True when every digit in the store is a legal BCD code.
  function automatic logic digits_valid(input digit_t ds [DIGIT_COUNT]);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (ds[i] > DIGIT_NINE) ok = 1'b0;
    end
    digits_valid = ok;
  endfunction

endpackage

FILE: rtl/binary_to_decimal_ascii.sv
// ---------------------------------------------------------------------------
// binary_to_decimal_ascii
// 64-bit unsigned binary to decimal ASCII text, one character per output beat.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream  (in_*):  one request per 64-bit value on in_tdata.
//   Output stream (out_*): one beat per decimal digit, most significant first,
//                          ASCII '0'..'9' in out_tdata[5:0]; out_tlast marks
//                          the least significant digit. Leading zeros are
//                          dropped; a zero value yields the single beat "0".
// Flow: input stage register, then the queue, then shift-and-double over
//   all 64 input bits (one input bit per cycle in the converter; a zero value
//   skips this), then the suppressed leading zeros are skipped before the
//   first digit appears. The converter handles one value at a time: it
//   converts, skips leading zeros and emits digits as the receiver takes
//   them. The input stage and a two-entry queue keep accepting requests
//   while the converter is busy.
// Reset (rst_n low, synchronous): queue emptied, converter idle, no output.
// Stall: out_tready low freezes the pending digit in the output register;
//   the converter waits, and input backs up once the queue is full.
// ---------------------------------------------------------------------------
module binary_to_decimal_ascii (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [b2da_pkg::IN_TDATA_W-1:0]      in_tdata,   // [63:0] value
  // output stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [b2da_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [5:0] digit_char, [7:6] zero
  output logic                                 out_tlast   // last_digit
);
  import b2da_pkg::*;

  // front -> queue
  logic    push;
  qentry_t push_data;
  logic    q_full;

  // queue -> back
  logic    q_pop;
  qentry_t q_head;
  logic    q_empty;

  // input stage: registers the request and tags zero values
  b2da_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  // decouples input stage from the converter
  b2da_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // double dabble over 20 BCD digits, then character output
  b2da_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

FILE: rtl/b2da_front.sv
// ---------------------------------------------------------------------------
// b2da_front
// Input stage: takes requests, flags zero values, hands them to the queue.
// ---------------------------------------------------------------------------
module b2da_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [b2da_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                push,
  output b2da_pkg::qentry_t                   push_data,
  input  logic                                q_full
);
  import b2da_pkg::*;

  logic    hold_valid_r;
  qentry_t hold_r;

  assign push      = hold_valid_r && !q_full;
  assign push_data = hold_r;
  assign in_tready = !hold_valid_r || !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      hold_valid_r <= 1'b1;
    end else if (push) begin
      hold_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_r.value   <= in_tdata[VALUE_BITS-1:0];
      hold_r.is_zero <= (in_tdata[VALUE_BITS-1:0] == '0);
    end
  end

endmodule

FILE: rtl/b2da_queue.sv
// ---------------------------------------------------------------------------
// b2da_queue
// Short FIFO between the input stage and the converter.
// ---------------------------------------------------------------------------
module b2da_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  b2da_pkg::qentry_t   push_data,
  output logic                full,
  input  logic                pop,
  output b2da_pkg::qentry_t   head,
  output logic                empty
);
  import b2da_pkg::*;

  qentry_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) ptr_inc = '0;
    else                                 ptr_inc = p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: rtl/b2da_back.sv
// ---------------------------------------------------------------------------
// b2da_back
// Converter: bit-serial double dabble, then digit-by-digit ASCII output.
// ---------------------------------------------------------------------------
`include "binary_to_decimal_ascii_defines.svh"

module b2da_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_empty,
  input  b2da_pkg::qentry_t                    q_head,
  output logic                                 q_pop,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [b2da_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                 out_tlast
);
  import b2da_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

  state_t                  state_r,     state_nxt;
  logic [VALUE_BITS-1:0]   sh_r,        sh_nxt;
  logic [BIT_CNT_W-1:0]    bit_cnt_r,   bit_cnt_nxt;
  digit_t                  digits_r [DIGIT_COUNT];
  digit_t                  digits_nxt [DIGIT_COUNT];
  logic [REM_W-1:0]        rem_r,       rem_nxt;
  logic                    started_r,   started_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]       out_char_r,  out_char_nxt;
  logic                    out_last_r,  out_last_nxt;

  logic                    slot_free;
  logic                    skip_zero;
  logic                    load;

  assign slot_free = !out_valid_r || out_tready;
  assign skip_zero = !started_r && (digits_r[0] == '0) && (rem_r > REM_W'(1));
  assign load      = (state_r == S_EMIT) && !skip_zero && slot_free;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-CHAR_W){1'b0}}, out_char_r};
  assign out_tlast  = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    sh_nxt        = sh_r;
    bit_cnt_nxt   = bit_cnt_r;
    digits_nxt    = digits_r;
    rem_nxt       = rem_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          for (int i = 0; i < DIGIT_COUNT; i++) digits_nxt[i] = '0;
          sh_nxt      = q_head.value;
          bit_cnt_nxt = BIT_CNT_W'(VALUE_BITS - 1);
          rem_nxt     = REM_W'(DIGIT_COUNT);
          started_nxt = 1'b0;
          // zero skips conversion: cleared store already reads as "0"
          state_nxt   = q_head.is_zero ? S_EMIT : S_CONV;
        end
      end
      S_CONV: begin
        // digit 0 is most significant; carry out of a digit is d >= 5
        for (int i = 0; i < DIGIT_COUNT - 1; i++) begin
          digits_nxt[i] = dbl_digit(digits_r[i], digits_r[i+1] >= DIGIT_FIVE);
        end
        digits_nxt[DIGIT_COUNT-1] = dbl_digit(digits_r[DIGIT_COUNT-1],
                                              sh_r[VALUE_BITS-1]);
        sh_nxt      = sh_r << 1;
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == '0) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (skip_zero || load) begin
          for (int i = 0; i < DIGIT_COUNT - 1; i++) digits_nxt[i] = digits_r[i+1];
          digits_nxt[DIGIT_COUNT-1] = '0;
          rem_nxt = rem_r - 1'b1;
        end
        if (load) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + CHAR_W'(digits_r[0]);
          out_last_nxt  = (rem_r == REM_W'(1));
          started_nxt   = 1'b1;
          if (rem_r == REM_W'(1)) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      rem_r       <= '0;
      bit_cnt_r   <= '0;
      for (int i = 0; i < DIGIT_COUNT; i++) digits_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
      rem_r       <= rem_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      digits_r    <= digits_nxt;
    end
    sh_r       <= sh_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // conversion never produces a digit; a taken slot stays empty
  `B2DA_ASSERT_NEXT(a_conv_no_out, (state_r == S_CONV) && slot_free, !out_valid_r, "digit produced during conversion")
  // store holds legal BCD at all times
  `B2DA_ASSERT_NOW(a_bcd, 1'b1, digits_valid(digits_r), "non-BCD digit in store")
  // last digit of a run sends the converter back to idle
  `B2DA_ASSERT_NEXT(a_last_idle, load && (rem_r == REM_W'(1)), (state_r == S_IDLE) && out_last_r, "run did not end after last digit")
  // pending character is always a decimal digit
  `B2DA_ASSERT_NOW(a_char_rng, out_valid_r, (out_char_r >= ASCII_ZERO) && (out_char_r <= ASCII_ZERO + CHAR_W'(9)), "character out of digit range")

endmodule

FILE: verif/decimal_text_board_pkg.sv
// ----------------------------------------------------------------------------
// decimal_text_board_pkg
// Expected-digit tracking for the binary to decimal ASCII converter bench.
// ----------------------------------------------------------------------------
package decimal_text_board_pkg;

  import b2da_pkg::*;

  typedef struct {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
  } digit_beat_t;

  class decimal_text_board;
    digit_beat_t digits_due[$];
    int          mismatches;
    int          digits_checked;

    function new();
      mismatches     = 0;
      digits_checked = 0;
    endfunction

    // Double-dabble over the full value width, MSB first, then queue the
    // digits from the leading one down to the units digit.
    function void add_value(logic [VALUE_BITS-1:0] value);
      logic [DIGIT_W-1:0] store [DIGIT_COUNT];
      int                 lead;
      int                 carry;
      int                 twice;
      digit_beat_t        beat;
      foreach (store[i]) store[i] = '0;
      lead = DIGIT_COUNT - 1;
      for (int b = VALUE_BITS - 1; b >= 0; b--) begin
        carry = value[b];
        for (int pos = DIGIT_COUNT - 1; pos >= lead; pos--) begin
          twice = store[pos] * 2 + carry;
          if (twice >= 10) begin
            store[pos] = DIGIT_W'(twice - 10);
            carry      = 1;
          end else begin
            store[pos] = DIGIT_W'(twice);
            carry      = 0;
          end
        end
        // carry past the top digit is dropped
        if (carry != 0 && lead > 0) begin
          lead        = lead - 1;
          store[lead] = DIGIT_W'(carry);
        end
      end
      for (int pos = lead; pos < DIGIT_COUNT; pos++) begin
        beat.digit_char = CHAR_W'(store[pos] + ASCII_ZERO);
        beat.last_digit = (pos == DIGIT_COUNT - 1);
        digits_due.push_back(beat);
      end
    endfunction

    function void check_digit(logic [CHAR_W-1:0] digit_char, logic last_digit);
      digit_beat_t want;
      digits_checked++;
      if (digits_due.size() == 0) begin
        $error("unexpected digit: got digit_char %0d last_digit %0d",
               digit_char, last_digit);
        mismatches++;
      end else begin
        want = digits_due.pop_front();
        if (digit_char !== want.digit_char) begin
          $error("digit_char mismatch: expected %0d, got %0d",
                 want.digit_char, digit_char);
          mismatches++;
        end
        if (last_digit !== want.last_digit) begin
          $error("last_digit mismatch: expected %0d, got %0d",
                 want.last_digit, last_digit);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return digits_due.size();
    endfunction
  endclass

endpackage

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives 64-bit values into the decimal converter and checks every ASCII
// digit beat, including tlast on the units digit, against a local
// double-dabble predictor. Both stream sides throttle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import b2da_pkg::*;
  import decimal_text_board_pkg::*;

  localparam int RANDOM_VALUES = 98;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int TAIL_CYCLES   = 120;   // > one full conversion plus digits

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;

  decimal_text_board board;
  bit                calm = 1'b0;   // no throttling on either side while set
  int                cycles = 0;
  int                values_sent = 0;
  int                zero_values = 0;

  binary_to_decimal_ascii dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [63:0] value
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [5:0] digit_char, [7:6] zero
    .out_tlast  (out_tlast)    // last_digit
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver backpressure, changed on the falling edge only.
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 36);
  end

  // Sample digit beats at the rising edge, before the DUT updates.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_digit(out_tdata[CHAR_W-1:0], out_tlast);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits still due", cycles, board.pending());
      $display("FAIL");
      $finish;
    end
  end

  // One request: optional idle gap (valid low, junk data), then hold
  // valid until the handshake lands.
  task automatic send_value(logic [VALUE_BITS-1:0] value);
    if (!calm) begin
      while ($urandom_range(99) < 36) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        in_tdata  <= {$urandom, $urandom};
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.add_value(value);
    values_sent++;
    if (value == '0) zero_values++;
  endtask

  // Drop valid and hold off until every digit owed has come out.
  task automatic drain_output();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  logic [VALUE_BITS-1:0] directed_values [$] = '{
    64'd0,                       // single '0' beat
    64'd1, 64'd9, 64'd10, 64'd19, 64'd99, 64'd100,
    64'd4294967295, 64'd4294967296,   // 32-bit boundary
    64'd999999999999999999,
    64'd1000000000000000000,
    64'd9999999999999999999,
    64'd10000000000000000000,         // first 20-digit value
    64'd12345678901234567890,
    64'hFFFF_FFFF_FFFF_FFFF,          // widest output, 20 digits
    64'd0,                            // zero right after the widest
    64'h8000_0000_0000_0000,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'h5555_5555_5555_5555,
    64'd1099511627776,
    64'd100000000000
  };

  initial begin
    logic [VALUE_BITS-1:0] value;
    int                    width;
    board = new();

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed values
    foreach (directed_values[i]) send_value(directed_values[i]);

    // random values of random magnitude so digit counts spread from 1 to 20
    for (int i = 0; i < RANDOM_VALUES; i++) begin
      calm = (i >= 30 && i < 60);
      if (i == 80) drain_output();   // converter and queue fully empty
      width = $urandom_range(VALUE_BITS, 1);
      value = {$urandom, $urandom};
      if (width < VALUE_BITS) value &= (64'd1 << width) - 64'd1;
      if ($urandom_range(19) == 0) value = '0;
      send_value(value);
    end
    calm = 1'b0;

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (board.pending() != 0) begin
      $error("%0d expected digits never arrived", board.pending());
      board.mismatches++;
    end

    $display("Converted %0d values (%0d of them zero), %0d digit beats checked,",
             values_sent, zero_values, board.digits_checked);
    $display("with random stalls on both sides and one full drain mid-run.");
    if (board.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
